/* hw/rtl/ulpu_pkg.sv */
// Shared types, codes and the u-law expander for the sample player.
package ulpu_pkg;

  typedef logic signed [15:0] sample_t;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_STOP  = 2'd2
  } req_t;

  // low seven bits of the format byte; bit 7 set means 16-bit PCM
  localparam logic [6:0] RATE_FULL    = 7'h01;
  localparam logic [6:0] RATE_HALF    = 7'h02;
  localparam logic [6:0] RATE_QUARTER = 7'h03;

  localparam int NUM_LANES  = 4;
  localparam int LANE_PTS   = 4;
  localparam int MAX_OUT    = 16;
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 24;

  // per-word control that travels with the data into the merge stage
  typedef struct packed {
    logic       pcm;
    logic [1:0] up;
    logic       ended;
  } word_ctl_t;

  // G.711 u-law to 16-bit linear
  function automatic sample_t ulaw_decode(input logic [7:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    u = ~code;
    t = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
    if (u[7]) begin
      ulaw_decode = sample_t'(16'h0084 - t);
    end else begin
      ulaw_decode = sample_t'(t - 16'h0084);
    end
  endfunction

endpackage

/* hw/rtl/ulpu_lane.sv */
// One lane: decodes one packed element and forms the interpolated points up to it.
module ulpu_lane import ulpu_pkg::*; (
  input  logic        pcm,
  input  logic [1:0]  up,
  input  logic [15:0] raw,
  input  sample_t     a,
  output sample_t     b,
  output sample_t     pts [LANE_PTS]
);

  logic signed [16:0] sum2;
  logic signed [17:0] sum_a3;
  logic signed [17:0] sum_b3;
  sample_t            mid;
  sample_t            q1;
  sample_t            q3;

  assign b = pcm ? sample_t'(raw) : ulaw_decode(raw[7:0]);

  // floor shifts of signed sums
  assign sum2   = 17'(a) + 17'(b);
  assign sum_a3 = (18'(a) <<< 1) + 18'(a) + 18'(b);
  assign sum_b3 = (18'(b) <<< 1) + 18'(b) + 18'(a);
  assign mid    = sample_t'(sum2 >>> 1);
  assign q1     = sample_t'(sum_a3 >>> 2);
  assign q3     = sample_t'(sum_b3 >>> 2);

  always_comb begin
    pts[0] = b;
    pts[1] = b;
    pts[2] = b;
    pts[3] = b;
    case (up)
      2'd1: begin
        pts[0] = mid;
        pts[1] = b;
      end
      2'd2: begin
        pts[0] = q1;
        pts[1] = mid;
        pts[2] = q3;
        pts[3] = b;
      end
      default: begin
        pts[0] = b;
      end
    endcase
  end

endmodule

/* hw/rtl/ulpu_merge.sv */
// Merge: packs lane points in output order; shifts out one per cycle with smp_ready.
module ulpu_merge import ulpu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  word_ctl_t ctl,
  input  sample_t   lane_pts [NUM_LANES][LANE_PTS],
  output logic      can_load,
  output logic      smp_valid,
  input  logic      smp_ready,
  output sample_t   sample,
  output logic      last_of_word,
  output logic      play_ended
);

  sample_t            packed_pts [MAX_OUT];
  sample_t            obuf [MAX_OUT];
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n_pts;
  logic [CNT_W-1:0]   base;
  logic               ended;
  logic               take;

  always_comb begin
    for (int k = 0; k < MAX_OUT; k++) begin
      packed_pts[k] = '0;
    end
    case (ctl.up)
      2'd1: begin
        for (int k = 0; k < 8; k++) begin
          packed_pts[k] = lane_pts[k / 2][k % 2];
        end
      end
      2'd2: begin
        for (int k = 0; k < MAX_OUT; k++) begin
          packed_pts[k] = lane_pts[k / 4][k % 4];
        end
      end
      default: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          packed_pts[k] = lane_pts[k][0];
        end
      end
    endcase
  end

  assign base  = ctl.pcm ? CNT_W'(2) : CNT_W'(4);
  assign n_pts = base << ctl.up;

  assign smp_valid    = (cnt != '0);
  assign take         = smp_valid && smp_ready;
  assign last_of_word = (cnt == CNT_W'(1));
  assign play_ended   = ended && last_of_word;
  assign sample       = obuf[0];
  assign can_load     = !smp_valid || (take && last_of_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= n_pts;
    end else if (take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ended <= ctl.ended;
      for (int k = 0; k < MAX_OUT; k++) begin
        obuf[k] <= packed_pts[k];
      end
    end else if (take) begin
      for (int k = 0; k < MAX_OUT - 1; k++) begin
        obuf[k] <= obuf[k + 1];
      end
      obuf[MAX_OUT - 1] <= '0;
    end
  end

endmodule

/* hw/rtl/ulaw_pcm_sample_player_upsampler_core.sv */
// Top level: request decoding, playback state, decode lanes and output merge.
//
//  channel | signals                              | dir | meaning
//  req     | req_valid req_ready req_type word    | in  | start / data / stop transaction
//  smp     | smp_valid smp_ready sample           | out | one sample per transaction,
//          |   last_of_word play_ended            |     |   flags on the word's last one
//
// A data word gives 2 to 16 samples, sent from the merge shift register one per cycle
// while smp_ready is high. The word is decoded by four lanes the cycle after it is
// taken; the next word is taken while the current one drains. Start, stop and ignored
// requests give no output. Reset clears playback state and empties both stages.
// Output stalls back up through the merge stage to req_ready.
module ulaw_pcm_sample_player_upsampler_core import ulpu_pkg::*; #(
  parameter int BLOCK_SAMPLES = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [1:0]    req_type,
  input  logic [31:0]   word,
  output logic          smp_valid,
  input  logic          smp_ready,
  output logic [15:0]   sample,
  output logic          last_of_word,
  output logic          play_ended
);

  localparam int WW      = $clog2(BLOCK_SAMPLES / 2 + 1);
  localparam int WORDS_P0 = BLOCK_SAMPLES / 2;
  localparam int WORDS_P1 = BLOCK_SAMPLES / 4;
  localparam int WORDS_P2 = BLOCK_SAMPLES / 8;
  localparam int WORDS_U0 = BLOCK_SAMPLES / 4;
  localparam int WORDS_U1 = BLOCK_SAMPLES / 8;
  localparam int WORDS_U2 = BLOCK_SAMPLES / 16;
  localparam int CONS_0   = BLOCK_SAMPLES;
  localparam int CONS_1   = BLOCK_SAMPLES / 2;
  localparam int CONS_2   = BLOCK_SAMPLES / 4;

  // playback state
  logic [7:0]       format_mode;
  logic [LEN_W-1:0] remaining_length;
  logic [WW-1:0]    word_in_block;
  logic             clr_pending;

  // word stage
  logic             s1_valid;
  logic [31:0]      s1_word;
  word_ctl_t        s1_ctl;
  logic             s1_clr;
  sample_t          prior_sample;

  logic             req_acc;
  logic             data_acc;
  logic             s1_go;
  logic             can_load;
  logic             cur_pcm;
  logic [1:0]       cur_up;
  logic [WW:0]      words;
  logic [WW:0]      wib_inc;
  logic [LEN_W-1:0] consumed;
  logic             block_done;
  logic             will_end;
  logic [6:0]       hdr_rate;
  logic             hdr_ok;

  sample_t          lane_a   [NUM_LANES];
  sample_t          lane_b   [NUM_LANES];
  logic [15:0]      lane_raw [NUM_LANES];
  sample_t          lane_pts [NUM_LANES][LANE_PTS];
  sample_t          smp_out;

  assign s1_go     = s1_valid && can_load;
  assign req_ready = !s1_valid || s1_go;
  assign req_acc   = req_valid && req_ready;
  assign data_acc  = req_acc && (req_type == REQ_DATA) && (format_mode != 8'h00);

  assign cur_pcm  = format_mode[7];
  assign cur_up   = format_mode[1:0] - 2'd1;
  assign hdr_rate = word[30:24];
  assign hdr_ok   = (hdr_rate == RATE_FULL) || (hdr_rate == RATE_HALF) ||
                    (hdr_rate == RATE_QUARTER);

  always_comb begin
    case (cur_up)
      2'd1: begin
        words    = cur_pcm ? (WW+1)'(WORDS_P1) : (WW+1)'(WORDS_U1);
        consumed = LEN_W'(CONS_1);
      end
      2'd2: begin
        words    = cur_pcm ? (WW+1)'(WORDS_P2) : (WW+1)'(WORDS_U2);
        consumed = LEN_W'(CONS_2);
      end
      default: begin
        words    = cur_pcm ? (WW+1)'(WORDS_P0) : (WW+1)'(WORDS_U0);
        consumed = LEN_W'(CONS_0);
      end
    endcase
  end

  assign wib_inc    = {1'b0, word_in_block} + (WW+1)'(1);
  assign block_done = (wib_inc >= words);
  assign will_end   = block_done && (remaining_length <= consumed);

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode      <= 8'h00;
      remaining_length <= '0;
      word_in_block    <= '0;
      clr_pending      <= 1'b1;
      s1_valid         <= 1'b0;
    end else begin
      if (data_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (req_acc) begin
        case (req_type)
          REQ_START: begin
            format_mode      <= hdr_ok ? word[31:24] : 8'h00;
            remaining_length <= word[LEN_W-1:0];
            word_in_block    <= '0;
            clr_pending      <= 1'b1;
          end
          REQ_STOP: begin
            format_mode <= 8'h00;
          end
          REQ_DATA: begin
            if (format_mode != 8'h00) begin
              clr_pending <= 1'b0;
              if (block_done) begin
                word_in_block <= '0;
                if (will_end) begin
                  format_mode <= 8'h00;
                end else begin
                  remaining_length <= remaining_length - consumed;
                end
              end else begin
                word_in_block <= wib_inc[WW-1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_word      <= word;
      s1_ctl.pcm   <= cur_pcm;
      s1_ctl.up    <= cur_up;
      s1_ctl.ended <= will_end;
      s1_clr       <= clr_pending;
    end
    if (s1_go) begin
      prior_sample <= s1_ctl.pcm ? lane_b[1] : lane_b[3];
    end
  end

  // lanes: each previous lane's decoded point is the next lane's start point
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_raw[i] = {8'h00, s1_word[8*i +: 8]};
    end
    if (s1_ctl.pcm) begin
      lane_raw[0] = s1_word[15:0];
      lane_raw[1] = s1_word[31:16];
      lane_raw[2] = '0;
      lane_raw[3] = '0;
    end
    lane_a[0] = s1_clr ? sample_t'(0) : prior_sample;
    for (int i = 1; i < NUM_LANES; i++) begin
      lane_a[i] = lane_b[i - 1];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ulpu_lane u_lane (
      .pcm (s1_ctl.pcm),
      .up  (s1_ctl.up),
      .raw (lane_raw[g]),
      .a   (lane_a[g]),
      .b   (lane_b[g]),
      .pts (lane_pts[g])
    );
  end

  ulpu_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_go),
    .ctl          (s1_ctl),
    .lane_pts     (lane_pts),
    .can_load     (can_load),
    .smp_valid    (smp_valid),
    .smp_ready    (smp_ready),
    .sample       (smp_out),
    .last_of_word (last_of_word),
    .play_ended   (play_ended)
  );

  assign sample = smp_out;

`ifndef ASSERT_OFF
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    smp_valid && play_ended |-> last_of_word)
    else $error("play_ended without last_of_word");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_STOP) |=> (format_mode == 8'h00))
    else $error("stop did not end playback");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready && last_of_word && !s1_valid |=> !smp_valid)
    else $error("output valid with nothing loaded");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !can_load |=> s1_valid && $stable(s1_word))
    else $error("word stage lost a stalled word");
`endif

endmodule
